// File: design/hdg_pkg.sv
// shared types, constants and the arctangent table for the heading unit
`timescale 1ns / 1ps
`default_nettype none
package hdg_pkg;

   // angle fraction bits inside the cordic, prescale of the axis values
   localparam int ANG_FRAC = 20;
   localparam int PRESCALE_SHIFT = 8;
   localparam int TABLE_LEN = 24;

   // defaults and fixed output format
   localparam int CORDIC_STEPS = 16;
   localparam int FRACTION_BITS = 7;

   // field and datapath widths
   localparam int BYTE_W = 8;
   localparam int AXIS_W = 16;
   localparam int HEADING_W = 16;
   localparam int XY_W = 28;
   localparam int Z_W = 32;

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [Z_W-1:0] angle_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [HEADING_W-1:0] heading_type;

   // vector and accumulated angle as they travel down the pipeline
   typedef struct packed {
      xy_type x;
      xy_type y;
      angle_type z;
      logic zero;
   } cordic_vec_type;

   localparam angle_type HALF_TURN = angle_type'(180 * (2 ** ANG_FRAC));
   localparam angle_type FULL_TURN = angle_type'(360 * (2 ** ANG_FRAC));

   // rounding from the internal angle format to the heading format
   localparam int ROUND_SHIFT = ANG_FRAC - FRACTION_BITS;
   localparam logic [Z_W-1:0] ROUND_ADD = Z_W'(2 ** (ROUND_SHIFT - 1));
   localparam logic [Z_W-1:0] HEADING_MAX = Z_W'((2 ** HEADING_W) - 1);

   // atan(2^-i) in degrees, scaled by 2^20
   localparam angle_type ATAN_TAB [TABLE_LEN] = '{
      32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
      32'sd3750058, 32'sd1876857, 32'sd938658, 32'sd469357,
      32'sd234682, 32'sd117342, 32'sd58671, 32'sd29335,
      32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
      32'sd917, 32'sd458, 32'sd229, 32'sd115,
      32'sd57, 32'sd29, 32'sd14, 32'sd7
   };

endpackage
`default_nettype wire

// File: design/hdg_req_if.sv
// request channel: magnetometer x and y bytes with valid/ready
`timescale 1ns / 1ps
`default_nettype none
interface hdg_req_if;
   logic valid;
   logic ready;
   hdg_pkg::byte_type x_high;
   hdg_pkg::byte_type x_low;
   hdg_pkg::byte_type y_high;
   hdg_pkg::byte_type y_low;

   modport source (output valid, x_high, x_low, y_high, y_low, input ready);
   modport sink (input valid, x_high, x_low, y_high, y_low, output ready);
endinterface
`default_nettype wire

// File: design/hdg_rsp_if.sv
// response channel: heading word with valid/ready
`timescale 1ns / 1ps
`default_nettype none
interface hdg_rsp_if;
   logic valid;
   logic ready;
   hdg_pkg::heading_type heading;

   modport source (output valid, heading, input ready);
   modport sink (input valid, heading, output ready);
endinterface
`default_nettype wire

// File: design/hdg_pre.sv
// input stage: byte assembly, prescale and left half plane rotation
`timescale 1ns / 1ps
`default_nettype none
module hdg_pre (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire hdg_pkg::byte_type      x_high,
   input  wire hdg_pkg::byte_type      x_low,
   input  wire hdg_pkg::byte_type      y_high,
   input  wire hdg_pkg::byte_type      y_low,
   output      logic                   in_ready,
   output      logic                   out_valid,
   output      hdg_pkg::cordic_vec_type out_vec,
   input  wire logic                   out_ready
);

   logic valid_ff, valid_in;
   hdg_pkg::cordic_vec_type vec_ff, vec_in;
   logic signed [hdg_pkg::AXIS_W-1:0] x_raw, y_raw;
   hdg_pkg::xy_type x_scaled, y_scaled;

   assign in_ready = !valid_ff || out_ready;
   assign x_raw = {x_high, x_low};
   assign y_raw = {y_high, y_low};
   assign x_scaled = hdg_pkg::xy_type'(x_raw) <<< hdg_pkg::PRESCALE_SHIFT;
   assign y_scaled = hdg_pkg::xy_type'(y_raw) <<< hdg_pkg::PRESCALE_SHIFT;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      vec_in = vec_ff;
      if (in_ready) begin
         vec_in.zero = (x_raw == '0) && (y_raw == '0);
         if (x_raw < 0) begin
            // turn by 180 degrees into the right half plane
            vec_in.x = -x_scaled;
            vec_in.y = -y_scaled;
            vec_in.z = (y_raw >= 0) ? hdg_pkg::HALF_TURN : -hdg_pkg::HALF_TURN;
         end else begin
            vec_in.x = x_scaled;
            vec_in.y = y_scaled;
            vec_in.z = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec = vec_ff;

endmodule
`default_nettype wire

// File: design/hdg_cordic_stage.sv
// one registered cordic vectoring iteration
`timescale 1ns / 1ps
`default_nettype none
module hdg_cordic_stage #(
   parameter int STEP = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire hdg_pkg::cordic_vec_type in_vec,
   output      logic                    in_ready,
   output      logic                    out_valid,
   output      hdg_pkg::cordic_vec_type out_vec,
   input  wire logic                    out_ready
);

   logic valid_ff, valid_in;
   hdg_pkg::cordic_vec_type vec_ff, vec_in;
   hdg_pkg::xy_type x_shift, y_shift;

   assign in_ready = !valid_ff || out_ready;
   assign x_shift = in_vec.x >>> STEP;
   assign y_shift = in_vec.y >>> STEP;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      vec_in = vec_ff;
      if (in_ready) begin
         vec_in.zero = in_vec.zero;
         // rotate toward the x axis, y strictly positive turns clockwise
         if (in_vec.y > 0) begin
            vec_in.x = in_vec.x + y_shift;
            vec_in.y = in_vec.y - x_shift;
            vec_in.z = in_vec.z + hdg_pkg::ATAN_TAB[STEP];
         end else begin
            vec_in.x = in_vec.x - y_shift;
            vec_in.y = in_vec.y + x_shift;
            vec_in.z = in_vec.z - hdg_pkg::ATAN_TAB[STEP];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec = vec_ff;

endmodule
`default_nettype wire

// File: design/hdg_post.sv
// output stage: offset, clamp, round and saturate into the heading word
`timescale 1ns / 1ps
`default_nettype none
module hdg_post (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire hdg_pkg::cordic_vec_type in_vec,
   output      logic                    in_ready,
   output      logic                    out_valid,
   output      hdg_pkg::heading_type    heading,
   input  wire logic                    out_ready
);

   logic valid_ff, valid_in;
   hdg_pkg::heading_type heading_ff, heading_in;
   hdg_pkg::angle_type h_sum, h_clamp;
   logic [hdg_pkg::Z_W-1:0] q_wide;

   assign in_ready = !valid_ff || out_ready;
   assign h_sum = in_vec.z + hdg_pkg::HALF_TURN;

   always_comb begin
      if (in_vec.zero) begin
         h_clamp = hdg_pkg::HALF_TURN;
      end else if (h_sum < 0) begin
         h_clamp = '0;
      end else if (h_sum > hdg_pkg::FULL_TURN) begin
         h_clamp = hdg_pkg::FULL_TURN;
      end else begin
         h_clamp = h_sum;
      end
   end

   // round to nearest, ties up
   assign q_wide = (unsigned'(h_clamp) + hdg_pkg::ROUND_ADD) >> hdg_pkg::ROUND_SHIFT;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      heading_in = heading_ff;
      if (in_ready) begin
         heading_in = (q_wide > hdg_pkg::HEADING_MAX) ? '1
                                                      : q_wide[hdg_pkg::HEADING_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      heading_ff <= heading_in;
   end

   assign out_valid = valid_ff;
   assign heading = heading_ff;

endmodule
`default_nettype wire

// File: design/magnetometer_heading_atan2_unit.sv
// top level: pipelined cordic compass heading from magnetometer x/y bytes
`timescale 1ns / 1ps
`default_nettype none
// channel   port      dir   word
// -------   -------   ---   -------------------------------------------
// request   req_word  in    x_high, x_low, y_high, y_low (8 bits each)
// response  rsp_word  out   heading (16 bits, 1/128 degree, 0 to 360)
//
// one word per cycle enters and leaves while the response side takes; there is
// one register stage per cordic iteration plus input and output stages
// every stage holds its own valid bit and takes a new word when it is empty
// or its successor takes; a stall fills bubbles first and loses nothing
// synchronous active high reset clears only the valid bits
module magnetometer_heading_atan2_unit #(
   parameter int CORDIC_STEPS = hdg_pkg::CORDIC_STEPS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hdg_req_if.sink    req_word,
   hdg_rsp_if.source  rsp_word
);

   // iterations past the angle table are not run
   localparam int RUN_STEPS = (CORDIC_STEPS < hdg_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                                 : hdg_pkg::TABLE_LEN;

   // pipe point k sits before cordic iteration k, point RUN_STEPS feeds the output
   logic                    pipe_valid [RUN_STEPS+1];
   logic                    pipe_ready [RUN_STEPS+1];
   hdg_pkg::cordic_vec_type pipe_vec   [RUN_STEPS+1];

   // decode, prescale, fold left half plane
   hdg_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_word.valid),
      .x_high    (req_word.x_high),
      .x_low     (req_word.x_low),
      .y_high    (req_word.y_high),
      .y_low     (req_word.y_low),
      .in_ready  (req_word.ready),
      .out_valid (pipe_valid[0]),
      .out_vec   (pipe_vec[0]),
      .out_ready (pipe_ready[0])
   );

   // one stage per vectoring iteration
   for (genvar k = 0; k < RUN_STEPS; k++) begin : g_step
      hdg_cordic_stage #(
         .STEP (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pipe_valid[k]),
         .in_vec    (pipe_vec[k]),
         .in_ready  (pipe_ready[k]),
         .out_valid (pipe_valid[k+1]),
         .out_vec   (pipe_vec[k+1]),
         .out_ready (pipe_ready[k+1])
      );
   end

   // add 180 degrees, clamp, round, saturate
   hdg_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pipe_valid[RUN_STEPS]),
      .in_vec    (pipe_vec[RUN_STEPS]),
      .in_ready  (pipe_ready[RUN_STEPS]),
      .out_valid (rsp_word.valid),
      .heading   (rsp_word.heading),
      .out_ready (rsp_word.ready)
   );

endmodule
`default_nettype wire

// File: tb/sv/magnetometer_heading_atan2_unit_test.sv
// self-checking bench for the pipelined cordic compass heading unit
`timescale 1ns / 1ps

class heading_scoreboard;
   typedef struct {
      logic [15:0] x;
      logic [15:0] y;
      hdg_pkg::heading_type heading;
   } reading_type;

   localparam longint HALF = longint'(180) <<< hdg_pkg::ANG_FRAC;
   localparam longint FULL = longint'(360) <<< hdg_pkg::ANG_FRAC;
   localparam int RSHIFT = hdg_pkg::ANG_FRAC - hdg_pkg::FRACTION_BITS;

   reading_type headings_due[$];
   int errors;
   int steps;

   function new(int n);
      steps = n;
      errors = 0;
   endfunction

   // bit-true heading: 16-bit axes, prescale, cordic vectoring, clamp, round, saturate
   function automatic hdg_pkg::heading_type predict_heading(logic [15:0] xw, logic [15:0] yw);
      logic signed [15:0] xs;
      logic signed [15:0] ys;
      longint vx;
      longint vy;
      longint ang;
      longint hx;
      longint hy;
      longint h;
      longint q;
      xs = xw;
      ys = yw;
      if (xs == 0 && ys == 0) begin
         h = HALF;
      end else begin
         vx = longint'(xs) * (longint'(1) <<< hdg_pkg::PRESCALE_SHIFT);
         vy = longint'(ys) * (longint'(1) <<< hdg_pkg::PRESCALE_SHIFT);
         ang = 0;
         // left half plane: turn by half a circle first
         if (vx < 0) begin
            ang = (vy >= 0) ? HALF : -HALF;
            vx = -vx;
            vy = -vy;
         end
         for (int i = 0; i < steps && i < hdg_pkg::TABLE_LEN; i++) begin
            hx = vx >>> i;
            hy = vy >>> i;
            if (vy > 0) begin
               vx = vx + hy;
               vy = vy - hx;
               ang = ang + longint'(hdg_pkg::ATAN_TAB[i]);
            end else begin
               vx = vx - hy;
               vy = vy + hx;
               ang = ang - longint'(hdg_pkg::ATAN_TAB[i]);
            end
         end
         h = ang + HALF;
         if (h < 0) h = 0;
         if (h > FULL) h = FULL;
      end
      q = (h + (longint'(1) <<< (RSHIFT - 1))) >>> RSHIFT;
      if (q > 65535) q = 65535;
      return q[15:0];
   endfunction

   function void note_reading(logic [15:0] xw, logic [15:0] yw);
      reading_type r;
      r.x = xw;
      r.y = yw;
      r.heading = predict_heading(xw, yw);
      headings_due.push_back(r);
   endfunction

   function void check_heading(hdg_pkg::heading_type got);
      reading_type r;
      if (headings_due.size() == 0) begin
         $display("%0t: unexpected heading word, expected none, got %0d", $time, got);
         errors++;
      end else begin
         r = headings_due.pop_front();
         if (got !== r.heading) begin
            $display("%0t: heading for x=%h y=%h, expected %0d, got %0d",
                     $time, r.x, r.y, r.heading, got);
            errors++;
         end
      end
   endfunction

   function int pending();
      return headings_due.size();
   endfunction
endclass

module magnetometer_heading_atan2_unit_test;

   localparam int STEPS = hdg_pkg::CORDIC_STEPS;
   localparam int N_DIRECTED = 24;
   localparam int N_RANDOM = 1526;
   // words from this index on go through with no gaps and no stalls
   localparam int CALM_FROM = 1300;

   // directed x/y pairs: zero vector, axes, full-scale corners, unit steps,
   // negative x with y at zero or just off it (the +/-180 start), odd byte mixes
   localparam logic [15:0] DIR_X [N_DIRECTED] = '{
      16'h0000, 16'h0001, 16'hffff, 16'h0000, 16'h0000, 16'h7fff,
      16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h8000,
      16'h7fff, 16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'hff9c,
      16'hfed4, 16'hfed4, 16'h00ff, 16'h7f80, 16'h0005, 16'hfff9
   };
   localparam logic [15:0] DIR_Y [N_DIRECTED] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hffff, 16'h0000,
      16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
      16'h8000, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'h0000,
      16'h0001, 16'hffff, 16'hff00, 16'h80ff, 16'hfffb, 16'h0007
   };

   logic clock;
   logic reset;
   bit steady;

   hdg_req_if req_word();
   hdg_rsp_if rsp_word();

   heading_scoreboard board;

   magnetometer_heading_atan2_unit #(
      .CORDIC_STEPS(STEPS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_word(req_word),
      .rsp_word(rsp_word)
   );

   always #10 clock = ~clock;

   // hard stop in case the pipeline hangs
   initial begin
      #10_000_000;
      $display("magnetometer_heading_atan2_unit_test: done, errors");
      $finish;
   end

   // result side: accepted heading words go straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_word.valid === 1'b1 && rsp_word.ready === 1'b1) begin
         board.check_heading(rsp_word.heading);
      end
   end

   // result side back-pressure: random stall bursts until the calm stretch
   initial begin
      rsp_word.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!steady && $urandom_range(0, 4) == 0) begin
            rsp_word.ready <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge clock);
         end else begin
            rsp_word.ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_word(input logic [15:0] xv, input logic [15:0] yv);
      req_word.valid <= 1'b1;
      req_word.x_high <= xv[15:8];
      req_word.x_low <= xv[7:0];
      req_word.y_high <= yv[15:8];
      req_word.y_low <= yv[7:0];
      @(posedge clock);
      while (req_word.ready !== 1'b1) @(posedge clock);
      board.note_reading(xv, yv);
      @(negedge clock);
   endtask

   // sender gap before a word, skipped once the calm stretch starts
   task automatic maybe_gap();
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_word.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   // random axis value from one of a few shapes
   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h8001;
         2: return 16'hffff;
         3: return 16'h0000;
         4: return 16'h0001;
         default: return 16'h7fff;
      endcase
   endfunction

   function automatic logic [15:0] pick_small(int span);
      return 16'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   initial begin
      logic [15:0] xv;
      logic [15:0] yv;
      logic [15:0] mag;
      int kind;
      int sent;

      clock = 1'b0;
      reset = 1'b1;
      steady = 1'b0;
      sent = 0;
      req_word.valid = 1'b0;
      req_word.x_high = '0;
      req_word.x_low = '0;
      req_word.y_high = '0;
      req_word.y_low = '0;
      board = new(STEPS);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners and special cases
      for (int i = 0; i < N_DIRECTED; i++) begin
         maybe_gap();
         push_word(DIR_X[i], DIR_Y[i]);
         sent++;
      end

      // random words; half are full-range, the rest aim at the corner cases
      for (int i = 0; i < N_RANDOM; i++) begin
         if (sent >= CALM_FROM) steady = 1'b1;
         kind = $urandom_range(0, 9);
         case (kind) inside
            [0:4]: begin
               xv = 16'($urandom);
               yv = 16'($urandom);
            end
            5: begin
               // tiny vectors, zero vector among them
               xv = pick_small(8);
               yv = pick_small(8);
            end
            6: begin
               // one axis exactly zero
               if ($urandom_range(0, 1) == 1) begin
                  xv = 16'($urandom);
                  yv = '0;
               end else begin
                  xv = '0;
                  yv = 16'($urandom);
               end
            end
            7: begin
               // negative x with y around zero: wrap at 0 / 360 degrees
               xv = 16'h8000 | 16'($urandom);
               yv = pick_small(2);
            end
            8: begin
               xv = pick_extreme();
               yv = pick_extreme();
            end
            default: begin
               // diagonals, any quadrant
               mag = 16'($urandom_range(1, 32767));
               xv = ($urandom_range(0, 1) == 1) ? -mag : mag;
               yv = ($urandom_range(0, 1) == 1) ? -mag : mag;
            end
         endcase
         maybe_gap();
         push_word(xv, yv);
         sent++;
      end
      req_word.valid <= 1'b0;

      // drain, then give stray words a chance to show up
      while (board.pending() != 0) @(posedge clock);
      repeat (STEPS + 8) @(posedge clock);

      if (board.errors == 0) begin
         $display("magnetometer_heading_atan2_unit_test: done, clean");
      end else begin
         $display("magnetometer_heading_atan2_unit_test: done, errors");
      end
      $finish;
   end

endmodule
